@@ src/ffve_pkg.sv @@
// Shared types, character constants and helper functions for the form field
// value extractor. No dependencies.

package ffve_pkg;

  // Longest key the name compare walks through.
  localparam int unsigned KEY_MAX_BYTES = 8;
  localparam int unsigned LENGTH_BITS_DEFAULT = 16;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_W     = 8'h57;

  typedef enum logic [1:0] {
    REG_KEY_BYTES      = 2'd0,
    REG_KEY_LENGTH     = 2'd1,
    REG_VALUE_CAPACITY = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_PARAM  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FAIL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SCAN  = 2'd0,
    PH_VALUE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  // Results of one body byte: an optional decoded byte, then an optional status.
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_val;
    logic        has_status;
    status_t     code;
    logic [15:0] len;
  } result_pair_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h30;
    if (!(c >= 8'h30 && c <= 8'h39)) begin
      d = fold_case(c) - CH_W;
    end
    return d[3:0];
  endfunction

endpackage

@@ src/form_field_value_extractor.sv @@
// Form field value extractor: key match, percent decoding and result queue.
// Depends on ffve_pkg.

// Takes one body byte per cycle and emits the decoded value of the first field
// whose name equals the configured key (ASCII case-insensitive), then one status
// word at the final byte of each body. All per-byte work is one pass of logic
// between the accept edge and a two-entry result queue; each entry holds the
// words one byte produces. Sustained rate is one byte per cycle while results
// drain at one word per cycle; a final byte that also completes a decoded byte
// produces two words, byte word before status word. in_ready drops only when
// both queue entries are occupied. Registers sit at byte addresses 0 (key bytes),
// 8 (key length) and 16 (value capacity).

module form_field_value_extractor #(
  parameter int unsigned LENGTH_BITS = ffve_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // body stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  body_byte,
  input  logic        end_of_body,
  // result stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_status,
  output logic [7:0]  decoded_byte,
  output logic [1:0]  status_code,
  output logic [15:0] value_length,
  output logic        final_item,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [15:0] LEN_MASK16 = (LENGTH_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << LENGTH_BITS) - 32'd1);

  // configuration registers
  logic [63:0] key_bytes;
  logic [3:0]  key_length;
  logic [15:0] value_capacity;

  // body state
  logic                   at_field_start, at_field_start_next;
  logic                   name_matching, name_matching_next;
  logic [3:0]             compare_index, compare_index_next;
  ffve_pkg::phase_t       phase, phase_next;
  ffve_pkg::esc_t         escape_stage, escape_stage_next;
  logic [3:0]             high_nibble, high_nibble_next;
  logic [LENGTH_BITS-1:0] written_count, written_count_next;
  ffve_pkg::status_t      result_code, result_code_next;

  // result queue
  ffve_pkg::result_pair_t q [2];
  ffve_pkg::result_pair_t pair_next;
  ffve_pkg::result_pair_t head;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       byte_sent;

  logic in_fire, out_fire, push, pop, cfg_write;

  logic [3:0]  klen;
  logic [15:0] limit;
  logic [7:0]  kb;
  logic        cand;
  logic [3:0]  idx;
  logic        over_limit;
  ffve_pkg::status_t code;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes      <= 64'd0;
      key_length     <= 4'd0;
      value_capacity <= 16'd256;
    end else if (cfg_write) begin
      case (ffve_pkg::reg_index_t'(paddr[4:3]))
        ffve_pkg::REG_KEY_BYTES:      key_bytes <= pwdata;
        ffve_pkg::REG_KEY_LENGTH:     key_length <= pwdata[3:0];
        ffve_pkg::REG_VALUE_CAPACITY: value_capacity <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ffve_pkg::reg_index_t'(paddr[4:3]))
      ffve_pkg::REG_KEY_BYTES:      prdata = key_bytes;
      ffve_pkg::REG_KEY_LENGTH:     prdata = {60'd0, key_length};
      ffve_pkg::REG_VALUE_CAPACITY: prdata = {48'd0, value_capacity};
      default:                      prdata = 64'd0;
    endcase
  end

  // per-byte decode
  always_comb begin
    klen = (key_length > 4'(ffve_pkg::KEY_MAX_BYTES)) ?
           4'(ffve_pkg::KEY_MAX_BYTES) : key_length;
    limit = (value_capacity == 16'd0) ? 16'd0 : value_capacity - 16'd1;
    if (limit > LEN_MASK16) begin
      limit = LEN_MASK16;
    end
    over_limit = (32'(written_count) >= 32'(limit));

    at_field_start_next = at_field_start;
    name_matching_next  = name_matching;
    compare_index_next  = compare_index;
    phase_next          = phase;
    escape_stage_next   = escape_stage;
    high_nibble_next    = high_nibble;
    written_count_next  = written_count;
    result_code_next    = result_code;

    pair_next            = '0;
    pair_next.code       = ffve_pkg::ST_FOUND;

    cand = at_field_start || name_matching;
    idx  = at_field_start ? 4'd0 : compare_index;
    kb   = key_bytes[{idx[2:0], 3'b000} +: 8];
    code = ffve_pkg::ST_ABSENT;

    case (phase)
      ffve_pkg::PH_SCAN: begin
        if (cand) begin
          if (idx >= klen) begin
            if (body_byte == ffve_pkg::CH_EQ) begin
              phase_next         = ffve_pkg::PH_VALUE;
              written_count_next = '0;
              escape_stage_next  = ffve_pkg::ESC_NONE;
            end
            cand = 1'b0;
          end else if (body_byte != ffve_pkg::CH_AMP &&
                       ffve_pkg::fold_case(body_byte) == ffve_pkg::fold_case(kb)) begin
            idx = idx + 4'd1;
          end else begin
            cand = 1'b0;
          end
        end
        name_matching_next  = cand;
        compare_index_next  = idx;
        at_field_start_next = (body_byte == ffve_pkg::CH_AMP);
      end
      ffve_pkg::PH_VALUE: begin
        if (body_byte == ffve_pkg::CH_AMP) begin
          phase_next       = ffve_pkg::PH_DONE;
          result_code_next = (escape_stage != ffve_pkg::ESC_NONE) ?
                             ffve_pkg::ST_FAIL : ffve_pkg::ST_FOUND;
        end else if (value_capacity != 16'd0) begin
          if (escape_stage == ffve_pkg::ESC_NONE) begin
            if (over_limit) begin
              phase_next       = ffve_pkg::PH_DONE;
              result_code_next = ffve_pkg::ST_FAIL;
            end else if (body_byte == ffve_pkg::CH_PCT) begin
              escape_stage_next = ffve_pkg::ESC_HIGH;
            end else begin
              pair_next.has_byte = 1'b1;
              pair_next.byte_val = (body_byte == ffve_pkg::CH_PLUS) ?
                                   ffve_pkg::CH_SPACE : body_byte;
              written_count_next = written_count + LENGTH_BITS'(1);
            end
          end else if (!ffve_pkg::is_hex(body_byte)) begin
            phase_next       = ffve_pkg::PH_DONE;
            result_code_next = ffve_pkg::ST_FAIL;
          end else if (escape_stage == ffve_pkg::ESC_HIGH) begin
            high_nibble_next  = ffve_pkg::hex_value(body_byte);
            escape_stage_next = ffve_pkg::ESC_LOW;
          end else begin
            pair_next.has_byte = 1'b1;
            pair_next.byte_val = {high_nibble, ffve_pkg::hex_value(body_byte)};
            written_count_next = written_count + LENGTH_BITS'(1);
            escape_stage_next  = ffve_pkg::ESC_NONE;
          end
        end
      end
      default: ;
    endcase

    if (end_of_body) begin
      case (phase_next)
        ffve_pkg::PH_SCAN:  code = ffve_pkg::ST_ABSENT;
        ffve_pkg::PH_VALUE: code = (escape_stage_next != ffve_pkg::ESC_NONE) ?
                                   ffve_pkg::ST_FAIL : ffve_pkg::ST_FOUND;
        default:            code = result_code_next;
      endcase
      if (value_capacity == 16'd0) begin
        code = ffve_pkg::ST_PARAM;
      end
      pair_next.has_status = 1'b1;
      pair_next.code       = code;
      pair_next.len        = (code == ffve_pkg::ST_FOUND) ? 16'(written_count_next) : 16'd0;

      // back to the start-of-body state
      at_field_start_next = 1'b1;
      name_matching_next  = 1'b0;
      compare_index_next  = 4'd0;
      phase_next          = ffve_pkg::PH_SCAN;
      escape_stage_next   = ffve_pkg::ESC_NONE;
      high_nibble_next    = 4'd0;
      written_count_next  = '0;
      result_code_next    = ffve_pkg::ST_ABSENT;
    end
  end

  assign in_ready = (count != 2'd2);
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && (pair_next.has_byte || pair_next.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      at_field_start <= 1'b1;
      name_matching  <= 1'b0;
      compare_index  <= 4'd0;
      phase          <= ffve_pkg::PH_SCAN;
      escape_stage   <= ffve_pkg::ESC_NONE;
      high_nibble    <= 4'd0;
      written_count  <= '0;
      result_code    <= ffve_pkg::ST_ABSENT;
    end else if (in_fire) begin
      at_field_start <= at_field_start_next;
      name_matching  <= name_matching_next;
      compare_index  <= compare_index_next;
      phase          <= phase_next;
      escape_stage   <= escape_stage_next;
      high_nibble    <= high_nibble_next;
      written_count  <= written_count_next;
      result_code    <= result_code_next;
    end
  end

  // result queue: the byte word of an entry goes out before its status word
  assign head      = q[rd_ptr];
  assign out_valid = (count != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign pop       = out_fire && !(head.has_byte && head.has_status && !byte_sent);

  always_comb begin
    if (head.has_byte && !byte_sent) begin
      is_status    = 1'b0;
      decoded_byte = head.byte_val;
      status_code  = ffve_pkg::ST_FOUND;
      value_length = 16'd0;
      final_item   = 1'b0;
    end else begin
      is_status    = 1'b1;
      decoded_byte = 8'd0;
      status_code  = head.code;
      value_length = head.len;
      final_item   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      count     <= 2'd0;
      byte_sent <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
      // mark the byte word as taken, hold the status word of that entry
      if (pop) begin
        byte_sent <= 1'b0;
      end else if (out_fire) begin
        byte_sent <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= pair_next;
    end
  end

endmodule

@@ dv/form_field_value_extractor_test.sv @@
// Self-checking testbench for form_field_value_extractor: streams form bodies
// through the byte port under random flow control and predicts every result word.
// Depends on ffve_pkg and the block itself.
`timescale 1ns / 1ps

module form_field_value_extractor_test;
  import ffve_pkg::*;

  localparam int unsigned BODY_BYTES     = 950;
  localparam int unsigned PHASE_BYTES    = 70;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  decoded_byte;
    logic [1:0]  status_code;
    logic [15:0] value_length;
    logic        final_item;
  } result_word_t;

  // Tracks the extractor state and queues the words each body byte must produce.
  class field_value_scoreboard;
    logic [63:0]  key_bytes;
    logic [3:0]   key_length;
    logic [15:0]  value_capacity;
    logic         at_field_start;
    logic         name_matching;
    logic [3:0]   compare_index;
    phase_t       phase;
    esc_t         escape_stage;
    logic [3:0]   high_nibble;
    logic [15:0]  written_count;
    status_t      result_code;
    result_word_t expected_words[$];
    int unsigned  mismatches;

    function new();
      key_bytes      = '0;
      key_length     = '0;
      value_capacity = 16'd256;
      mismatches     = 0;
      restart_body();
    endfunction

    function void restart_body();
      at_field_start = 1'b1;
      name_matching  = 1'b0;
      compare_index  = '0;
      phase          = PH_SCAN;
      escape_stage   = ESC_NONE;
      high_nibble    = '0;
      written_count  = '0;
      result_code    = ST_ABSENT;
    endfunction

    function void set_register(reg_index_t idx, logic [63:0] value);
      case (idx)
        REG_KEY_BYTES:      key_bytes = value;
        REG_KEY_LENGTH:     key_length = value[3:0];
        REG_VALUE_CAPACITY: value_capacity = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function logic [7:0] lower_ascii(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function logic hex_digit(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function logic [3:0] digit_value(logic [7:0] c);
      logic [7:0] d;
      if (c >= "0" && c <= "9") begin
        d = c - "0";
      end else begin
        d = lower_ascii(c) - CH_W;
      end
      return d[3:0];
    endfunction

    function void push_word(logic is_status, logic [7:0] b, status_t code, logic [15:0] len);
      result_word_t w;
      w.is_status    = is_status;
      w.decoded_byte = b;
      w.status_code  = code;
      w.value_length = len;
      w.final_item   = is_status;
      expected_words.push_back(w);
    endfunction

    function void emit_value_byte(logic [7:0] b);
      push_word(1'b0, b, ST_FOUND, 16'd0);
      written_count = written_count + 16'd1;
    endfunction

    function void note_body_byte(logic [7:0] b, logic last);
      int unsigned klen;
      int unsigned idx;
      logic [15:0] limit;
      logic        cand;
      status_t     code;
      klen  = (key_length > KEY_MAX_BYTES) ? KEY_MAX_BYTES : key_length;
      limit = (value_capacity == 0) ? 16'd0 : value_capacity - 16'd1;
      case (phase)
        PH_SCAN: begin
          cand = at_field_start || name_matching;
          idx  = at_field_start ? 0 : compare_index;
          if (cand) begin
            if (idx >= klen) begin
              if (b == CH_EQ) begin
                phase         = PH_VALUE;
                written_count = '0;
                escape_stage  = ESC_NONE;
              end
              cand = 1'b0;
            end else if (b != CH_AMP && lower_ascii(b) == lower_ascii(key_bytes[8*idx +: 8])) begin
              idx++;
            end else begin
              cand = 1'b0;
            end
          end
          name_matching  = cand;
          compare_index  = 4'(idx);
          at_field_start = (b == CH_AMP);
        end
        PH_VALUE: begin
          if (b == CH_AMP) begin
            phase       = PH_DONE;
            result_code = (escape_stage != ESC_NONE) ? ST_FAIL : ST_FOUND;
          end else if (value_capacity != 0) begin
            if (escape_stage == ESC_NONE) begin
              if (written_count >= limit) begin
                phase       = PH_DONE;
                result_code = ST_FAIL;
              end else if (b == CH_PCT) begin
                escape_stage = ESC_HIGH;
              end else begin
                emit_value_byte((b == CH_PLUS) ? CH_SPACE : b);
              end
            end else if (!hex_digit(b)) begin
              phase       = PH_DONE;
              result_code = ST_FAIL;
            end else if (escape_stage == ESC_HIGH) begin
              high_nibble  = digit_value(b);
              escape_stage = ESC_LOW;
            end else begin
              emit_value_byte({high_nibble, digit_value(b)});
              escape_stage = ESC_NONE;
            end
          end
        end
        default: ;
      endcase

      if (last) begin
        if (phase == PH_SCAN) begin
          code = ST_ABSENT;
        end else if (phase == PH_VALUE) begin
          code = (escape_stage != ESC_NONE) ? ST_FAIL : ST_FOUND;
        end else begin
          code = result_code;
        end
        if (value_capacity == 0) begin
          code = ST_PARAM;
        end
        push_word(1'b1, 8'd0, code, (code == ST_FOUND) ? written_count : 16'd0);
        restart_body();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("is_status", want.is_status, got.is_status);
      compare_field("decoded_byte", want.decoded_byte, got.decoded_byte);
      compare_field("status_code", want.status_code, got.status_code);
      compare_field("value_length", want.value_length, got.value_length);
      compare_field("final_item", want.final_item, got.final_item);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  body_byte;
  logic        end_of_body;
  logic        out_valid;
  logic        out_ready;
  logic        is_status;
  logic [7:0]  decoded_byte;
  logic [1:0]  status_code;
  logic [15:0] value_length;
  logic        final_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  field_value_scoreboard board = new();

  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  bit           hold_request;
  int unsigned  total_bytes;
  int unsigned  stalled_cycles;
  logic [7:0]   body_q[$];
  logic [63:0]  key_text;
  logic [3:0]   key_len_cfg;
  result_word_t seen_word;

  form_field_value_extractor i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .body_byte    (body_byte),
    .end_of_body  (end_of_body),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_status    (is_status),
    .decoded_byte (decoded_byte),
    .status_code  (status_code),
    .value_length (value_length),
    .final_item   (final_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off per request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check words before noting the byte taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen_word.is_status    = is_status;
        seen_word.decoded_byte = decoded_byte;
        seen_word.status_code  = status_code;
        seen_word.value_length = value_length;
        seen_word.final_item   = final_item;
        board.check_word(seen_word);
      end
      if (in_valid && in_ready) begin
        board.note_body_byte(body_byte, end_of_body);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
          $display("form_field_value_extractor regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic send_body_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    body_byte   <= b;
    end_of_body <= last;
    do @(posedge clk); while (!in_ready);
    total_bytes++;
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) begin
      send_body_byte(body_q[i], i == body_q.size() - 1);
    end
    body_q.delete();
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(reg_index_t idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(logic [63:0] key, logic [3:0] klen, logic [15:0] cap);
    wait_for_drain();
    key_text    = key;
    key_len_cfg = klen;
    write_register(REG_KEY_BYTES, key);
    write_register(REG_KEY_LENGTH, {60'd0, klen});
    write_register(REG_VALUE_CAPACITY, {48'd0, cap});
  endtask

  task automatic set_idling();
    if (total_bytes < BODY_BYTES / 3) begin
      send_idle_pct = 22;
      recv_idle_pct = 48;
    end else if (total_bytes < 2 * BODY_BYTES / 3) begin
      send_idle_pct = 48;
      recv_idle_pct = 22;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      body_q.push_back(s[i]);
    end
  endtask

  function automatic logic [7:0] hex_char(int unsigned n);
    if (n < 10) begin
      return 8'("0" + n);
    end
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  // Any value byte but the field separator and the escape mark.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h21, 8'h7E));
    end while (c == CH_AMP || c == CH_PCT);
    return c;
  endfunction

  task automatic append_key_name(int unsigned upto);
    logic [7:0] c;
    for (int unsigned i = 0; i < upto; i++) begin
      c = key_text[8*i +: 8];
      if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
        c = c ^ 8'h20;
      end
      body_q.push_back(c);
    end
  endtask

  task automatic append_value(int unsigned tokens);
    int unsigned r;
    for (int unsigned i = 0; i < tokens; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        body_q.push_back(plain_char());
      end else if (r < 62) begin
        body_q.push_back(CH_PLUS);
      end else if (r < 88) begin
        body_q.push_back(CH_PCT);
        body_q.push_back(hex_char($urandom_range(0, 15)));
        body_q.push_back(hex_char($urandom_range(0, 15)));
      end else if (r < 94) begin
        body_q.push_back(CH_PCT);
        body_q.push_back(plain_char());
      end else begin
        body_q.push_back(CH_PCT);
        body_q.push_back(hex_char($urandom_range(0, 15)));
        body_q.push_back(plain_char());
      end
    end
  endtask

  task automatic append_other_field(int unsigned klen);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20 && klen > 0) begin
      // near miss: truncated key, or key with a trailing letter
      if ($urandom_range(0, 1)) begin
        append_key_name($urandom_range(0, klen - 1));
      end else begin
        append_key_name(klen);
        body_q.push_back(8'($urandom_range("a", "z")));
      end
    end else if (r < 35) begin
      append_key_name(klen);
    end else begin
      repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom_range("a", "z")));
    end
    if ($urandom_range(0, 99) < 85) begin
      body_q.push_back(CH_EQ);
    end
    append_value($urandom_range(0, 4));
  endtask

  task automatic build_form_body(bit long_value);
    int unsigned klen;
    int unsigned fields;
    int unsigned key_pos;
    int unsigned keep;
    klen    = (key_len_cfg > KEY_MAX_BYTES) ? KEY_MAX_BYTES : key_len_cfg;
    fields  = $urandom_range(1, 4);
    key_pos = long_value ? 0 : $urandom_range(0, fields);
    for (int unsigned f = 0; f < fields; f++) begin
      if (f > 0) begin
        body_q.push_back(CH_AMP);
      end
      if (f == key_pos) begin
        append_key_name(klen);
        body_q.push_back(CH_EQ);
        append_value(long_value ? 30 : $urandom_range(0, 6));
      end else begin
        append_other_field(klen);
      end
    end
    if (body_q.size() == 0) begin
      body_q.push_back(8'($urandom_range(0, 255)));
    end
    // broken body: cut short at a random byte
    if (!long_value && $urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, body_q.size());
      while (body_q.size() > keep) body_q.pop_back();
    end
  endtask

  task automatic build_noise_body();
    logic [7:0] marks[4];
    marks = '{CH_AMP, CH_EQ, CH_PCT, CH_PLUS};
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 9) < 3) begin
        body_q.push_back(marks[$urandom_range(0, 3)]);
      end else begin
        body_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  function automatic logic [63:0] random_key();
    logic [63:0] k;
    int unsigned r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        k[8*i +: 8] = 8'($urandom_range("a", "z")) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      end else if (r < 85) begin
        k[8*i +: 8] = 8'($urandom_range("0", "9"));
      end else begin
        k[8*i +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return k;
  endfunction

  initial begin
    int unsigned setting;
    int unsigned phase_start;
    int unsigned stop_at;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [15:0] cap;
    bit          hold_phase;
    bit          first_body;

    in_valid     <= 1'b0;
    body_byte    <= 8'd0;
    end_of_body  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    rst          <= 1'b1;
    hold_request = 1'b0;
    total_bytes  = 0;
    stalled_cycles = 0;
    key_text     = '0;
    key_len_cfg  = '0;
    set_idling();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // mixed-case match, plus sign, escape completed by the final byte
    write_settings(64'h0000_0000_0000_6241, 4'd2, 16'd256);
    load_text("ab=+%4F");
    send_body();
    // key in a later field, then a bad escape
    body_q.push_back(8'h00);
    load_text("&AB=%g");
    send_body();
    // one-byte body without the key
    body_q.push_back(8'hFF);
    send_body();
    write_settings(64'h0000_0000_0000_6241, 4'd2, 16'd0);
    load_text("ab=c");
    send_body();
    // value longer than the capacity allows
    write_settings(64'h0000_0000_0000_6241, 4'd2, 16'd2);
    load_text("aB=cd");
    send_body();
    // empty key; escape still open at the end of the body
    write_settings(64'h0, 4'd0, 16'd256);
    load_text("=%");
    send_body();

    stop_at = total_bytes + BODY_BYTES;
    setting = 0;
    while (total_bytes < stop_at) begin
      key        = random_key();
      klen       = 4'($urandom_range(0, 10));
      hold_phase = (setting % 7 == 4);
      case ($urandom_range(0, 7))
        0:       cap = 16'd0;
        1:       cap = 16'd1;
        2:       cap = 16'd2;
        3:       cap = 16'($urandom_range(3, 8));
        4:       cap = 16'hFFFF;
        5:       cap = 16'($urandom_range(9, 300));
        6:       cap = 16'($urandom);
        default: cap = 16'd256;
      endcase
      case (setting)
        0: begin
          key  = '1;
          klen = 4'd8;
          cap  = 16'hFFFF;
        end
        1: begin
          key  = '0;
          klen = 4'd0;
          cap  = 16'd1;
        end
        2: begin
          key[8*$urandom_range(0, 7) +: 8] = CH_AMP;
          klen = 4'd15;
        end
        default: ;
      endcase
      if (hold_phase) begin
        cap = 16'hFFFF;
      end
      write_settings(key, klen, cap);
      phase_start = total_bytes;
      first_body  = 1'b1;
      while (total_bytes - phase_start < PHASE_BYTES && total_bytes < stop_at) begin
        set_idling();
        if (first_body && hold_phase) begin
          // stall the result side while a long value streams in
          hold_request = 1'b1;
          build_form_body(1'b1);
        end else if ($urandom_range(0, 99) < 85) begin
          build_form_body(1'b0);
        end else begin
          build_noise_body();
        end
        send_body();
        first_body = 1'b0;
      end
      setting++;
    end

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("form_field_value_extractor regression: pass");
    end else begin
      $display("form_field_value_extractor regression: fail");
    end
    $finish;
  end

endmodule
